[src/rbsi_pkg.sv]
package rbsi_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

	localparam int REG_IDX_W = 3;
endpackage

[src/rbsi_if.sv]
interface rbsi_ray_if #(
	parameter int CW = 32
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] origin_x;
	logic signed [CW-1:0] origin_y;
	logic signed [CW-1:0] origin_z;
	logic signed [CW-1:0] dir_x;
	logic signed [CW-1:0] dir_y;
	logic signed [CW-1:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rbsi_hit_if #(
	parameter int CW = 32
);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic signed [CW-1:0] t_near;
	logic signed [CW-1:0] t_far;
	logic                 origin_inside;

	modport source (output valid, hit, t_near, t_far, origin_inside, input ready);
	modport sink (input valid, hit, t_near, t_far, origin_inside, output ready);
endinterface

[src/rbsi_div.sv]
// Pipelined restoring divider: one quotient bit per stage on unsigned magnitudes.
// Quotient magnitude computed with FB fraction bits and saturated.
module rbsi_div
	import rbsi_pkg::*;
#(
	parameter int CW = 32,
	parameter int FB = 16,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [CW:0]          num,
	input  logic [CW:0]          den,
	input  logic                 neg,
	input  logic [TW-1:0]        tag_in,
	output logic [CW-1:0]        mag,
	output logic [TW-1:0]        tag_out
);
	// quotient bits: enough to detect overflow beyond CW bits
	localparam int QB = CW + 1 + FB;
	localparam int NW = CW + 1 + FB;

	logic [NW-1:0] n_s [QB+1];
	logic [CW:0]   d_s [QB+1];
	logic [CW:0]   r_s [QB+1];
	logic [QB-1:0] q_s [QB+1];
	logic          neg_s [QB+1];
	logic [TW-1:0] tag_s [QB+1];

	assign n_s[0]   = {num, {FB{1'b0}}};
	assign d_s[0]   = den;
	assign r_s[0]   = '0;
	assign q_s[0]   = '0;
	assign neg_s[0] = neg;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < QB; i++) begin : g_st
		logic [CW+1:0] rs;
		logic [CW+1:0] diff;
		assign rs   = {r_s[i], n_s[i][NW-1-i]};
		assign diff = rs - {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1]   <= n_s[i];
				d_s[i+1]   <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!diff[CW+1]) begin
					r_s[i+1] <= diff[CW:0];
					q_s[i+1] <= {q_s[i][QB-2:0], 1'b1};
				end else begin
					r_s[i+1] <= rs[CW:0];
					q_s[i+1] <= {q_s[i][QB-2:0], 1'b0};
				end
			end
		end
	end

	logic [CW-1:0] lim;
	logic          ovf;
	assign lim = neg_s[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	assign ovf = q_s[QB] > {{(QB-CW){1'b0}}, lim};
	assign mag = ovf ? lim : q_s[QB][CW-1:0];
	assign tag_out = tag_s[QB];
endmodule

[src/rbsi_slab.sv]
// One axis: differences, two divides, zero-direction handling, ordering.
module rbsi_slab
	import rbsi_pkg::*;
#(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] bmin,
	input  logic signed [CW-1:0] bmax,
	input  logic signed [CW-1:0] o,
	input  logic signed [CW-1:0] d,
	output logic signed [CW-1:0] lo,
	output logic signed [CW-1:0] hi,
	output logic                 in_slab
);
	localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] TMIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW:0] da_s1, db_s1, dd_s1;
	logic               zero_s1, in_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			da_s1   <= {bmin[CW-1], bmin} - {o[CW-1], o};
			db_s1   <= {bmax[CW-1], bmax} - {o[CW-1], o};
			dd_s1   <= {d[CW-1], d};
			zero_s1 <= (d == '0);
			in_s1   <= (bmin <= o) && (o <= bmax);
		end
	end

	logic [CW:0] na, nb, dm;
	assign na = da_s1[CW] ? -da_s1 : da_s1;
	assign nb = db_s1[CW] ? -db_s1 : db_s1;
	assign dm = (dd_s1[CW] ? -dd_s1 : dd_s1) | {{CW{1'b0}}, zero_s1};

	logic [CW-1:0] ma, mb;
	logic [2:0]    ta, tb;
	logic          nega, negb;
	assign nega = da_s1[CW] != dd_s1[CW];
	assign negb = db_s1[CW] != dd_s1[CW];

	rbsi_div #(.CW(CW), .FB(FB), .TW(3)) u_div_a (
		.clk, .en, .num(na), .den(dm), .neg(nega),
		.tag_in({nega, zero_s1, in_s1}), .mag(ma), .tag_out(ta));
	rbsi_div #(.CW(CW), .FB(FB), .TW(3)) u_div_b (
		.clk, .en, .num(nb), .den(dm), .neg(negb),
		.tag_in({negb, 1'b0, 1'b0}), .mag(mb), .tag_out(tb));

	logic signed [CW-1:0] qa, qb;
	assign qa = ta[2] ? -ma : ma;
	assign qb = tb[2] ? -mb : mb;

	always_ff @(posedge clk) begin
		if (en) begin
			in_slab <= ta[0];
			if (ta[1]) begin
				lo <= ta[0] ? TMIN : TMAX;
				hi <= ta[0] ? TMAX : TMIN;
			end else begin
				lo <= (qa < qb) ? qa : qb;
				hi <= (qa < qb) ? qb : qa;
			end
		end
	end
endmodule

[src/ray_box_slab_intersect.sv]
// Ray versus axis-aligned box, slab method, fully pipelined.
// Channels: ray_in (sink) carries origin and direction per word; res_out
// (source) carries hit, t_near, t_far, origin_inside per word.
// Box bounds are written through cfg_we/cfg_idx/cfg_data, index 0..5 =
// min x,y,z then max x,y,z; writes only while the pipe is empty, a rule for
// the user that the block does not enforce. Stages: setup, the bit-per-stage
// divider, ordering, reduce and output; Q16.16 coordinates by default.
// Throughput: one word per cycle while res_out is not stalled.
// Reset clears all valid bits and loads the unit box [0,1]^3.
// A stall on res_out freezes the whole pipe; ray_in.ready falls with it,
// so no word is lost or repeated.
module ray_box_slab_intersect
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_idx,
	input  logic [COORD_WIDTH-1:0] cfg_data,
	rbsi_ray_if.sink               ray_in,
	rbsi_hit_if.source             res_out
);
	localparam int CW  = COORD_WIDTH;
	localparam int LAT = CW + FRAC_BITS + 1 + 3;

	logic signed [CW-1:0] bmin_q [3];
	logic signed [CW-1:0] bmax_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				bmin_q[k] <= '0;
				bmax_q[k] <= CW'(1) << FRAC_BITS;
			end
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MIN_X: bmin_q[0] <= cfg_data;
				REG_MIN_Y: bmin_q[1] <= cfg_data;
				REG_MIN_Z: bmin_q[2] <= cfg_data;
				REG_MAX_X: bmax_q[0] <= cfg_data;
				REG_MAX_Y: bmax_q[1] <= cfg_data;
				REG_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !res_out.valid || res_out.ready;
	assign ray_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], ray_in.valid};
	end

	logic signed [CW-1:0] o [3];
	logic signed [CW-1:0] d [3];
	logic signed [CW-1:0] lo [3];
	logic signed [CW-1:0] hi [3];
	logic                 ins [3];
	assign o[0] = ray_in.origin_x;
	assign o[1] = ray_in.origin_y;
	assign o[2] = ray_in.origin_z;
	assign d[0] = ray_in.dir_x;
	assign d[1] = ray_in.dir_y;
	assign d[2] = ray_in.dir_z;

	for (genvar k = 0; k < 3; k++) begin : g_ax
		rbsi_slab #(.CW(CW), .FB(FRAC_BITS)) u_slab (
			.clk, .en, .bmin(bmin_q[k]), .bmax(bmax_q[k]),
			.o(o[k]), .d(d[k]), .lo(lo[k]), .hi(hi[k]), .in_slab(ins[k]));
	end

	logic signed [CW-1:0] n01, f01, nr, fr;
	assign n01 = (lo[0] > lo[1]) ? lo[0] : lo[1];
	assign f01 = (hi[0] < hi[1]) ? hi[0] : hi[1];
	assign nr  = (lo[2] > n01) ? lo[2] : n01;
	assign fr  = (hi[2] < f01) ? hi[2] : f01;

	logic signed [CW-1:0] near_s2, far_s2;
	logic                 ins_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			near_s2 <= nr;
			far_s2  <= fr;
			ins_s2  <= ins[0] && ins[1] && ins[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_out.valid <= 1'b0;
		else if (en) res_out.valid <= vld_q[LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out.hit           <= near_s2 <= far_s2;
			res_out.t_near        <= near_s2;
			res_out.t_far         <= far_s2;
			res_out.origin_inside <= ins_s2;
		end
	end
endmodule

[src/rbsi_checker.sv]
module rbsi_checker
	import rbsi_pkg::*;
#(
	parameter int CW = COORD_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          hit,
	input logic [CW-1:0] t_near,
	input logic [CW-1:0] t_far
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(t_near) && $stable(t_far))
		else $error("result dropped under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipe stalled");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit == ($signed(t_near) <= $signed(t_far)))
		else $error("hit disagrees with interval");
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("valid after reset");
endmodule

bind ray_box_slab_intersect rbsi_checker #(.CW(COORD_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(ray_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready), .hit(res_out.hit),
	.t_near(res_out.t_near), .t_far(res_out.t_far));
